// ===== sv/sca_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab chunk allocator package
// Shared constants, codes, state and command types of the chunk allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned NumChunks  = 32;
  localparam int unsigned NumBuckets = NumChunks + 1;
  localparam int unsigned NumLinks   = NumSlots * NumChunks;

  localparam int unsigned SlotW    = 4;   // slot index
  localparam int unsigned IdxW     = 5;   // chunk index inside a block
  localparam int unsigned CntW     = 6;   // free count, hint, bucket, chunk link
  localparam int unsigned ListW    = 5;   // slot list link, NilSlot means none
  localparam int unsigned HandleW  = 9;
  localparam int unsigned BlkCntW  = 5;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CfgSizeW = 14;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  localparam logic [ListW-1:0]    NilSlot           = 5'd16;
  localparam logic [CntW-1:0]     ChunksPerBlockRst = 6'd32;
  localparam logic [CfgSizeW-1:0] ChunkSizeRst      = 14'd64;
  localparam logic [CntW-1:0]     MaxCpb            = 6'd32;
  localparam logic [CfgSizeW-1:0] MinChunkSize      = 14'd4;

  typedef enum logic [1:0] {
    StOk           = 2'd0,
    StSizeMismatch = 2'd1,
    StNoSlot       = 2'd2
  } status_e;

  typedef enum logic {
    ReqAlloc = 1'b0,
    ReqFree  = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChunksPerBlock = 1'b0,
    CfgChunkSize      = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    FsmIdle,
    FsmDispatch,
    FsmOpen,
    FsmFill,
    FsmOpenPushRd,
    FsmOpenPushWr,
    FsmAlHead,
    FsmAlLoad,
    FsmAlCheck,
    FsmAlRemove,
    FsmAlUpd,
    FsmAlPushRd,
    FsmAlPushWr,
    FsmAlHint,
    FsmFrLoad,
    FsmFrRemove,
    FsmFrUpd,
    FsmFrPushRd,
    FsmFrPushWr,
    FsmFinish
  } state_e;

  typedef enum logic [3:0] {
    CmdNone,
    CmdAccept,
    CmdErrSize,
    CmdErrSlot,
    CmdOpen,
    CmdFill,
    CmdPushRd,
    CmdPushWr,
    CmdHeadRd,
    CmdLoad,
    CmdRemove,
    CmdAlUpd,
    CmdAlHint,
    CmdFrLoad,
    CmdFrUpd,
    CmdFinish
  } cmd_e;

  typedef struct packed {
    logic is_free;
    logic size_ok;
    logic hint_zero;
    logic have_empty;
    logic hint_nonempty;
    logic slot_ok;
    logic free_ok;
    logic fill_last;
    logic release_blk;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== sv/slab_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab chunk allocator
// Fixed-size chunk allocator over sixteen block slots of up to 32 chunks.
// ----------------------------------------------------------------------------
// One request is worked on at a time and each gives one result. An allocate
// that has to open a new block first writes the chunk free list of the new
// block one link per cycle into the link memory. A free pushes the block back
// onto its bucket list only when the block stays in use. The next request can
// be taken in the cycle after the result is loaded into the output register.
// The controller steps through the slot tables and the bucket head memory one
// access at a time. A finished result waits in the output register while the
// next request is taken in.
module slab_chunk_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sca_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // request_size [15:0], chunk_handle [24:16], zero fill above
  input  logic [sca_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status [1:0], granted_handle [10:2], block_released [11],
  // blocks_in_use [16:12], zero fill above
  output logic [sca_pkg::OutDataW-1:0]  m_axis_tdata
);

  sca_pkg::cmd_e       cmd;
  sca_pkg::dp_status_t dp_status;

  sca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  sca_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/sca_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sca_datapath.sv =====
// ----------------------------------------------------------------------------
// Chunk allocator datapath
// Slot tables, bucket lists, chunk free lists, hint and result register.
// ----------------------------------------------------------------------------
module sca_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sca_pkg::cmd_e                 cmd_i,
  output sca_pkg::dp_status_t           status_o,
  input  logic                          cfg_we_i,
  input  logic [sca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sca_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [sca_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_user_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sca_pkg::OutDataW-1:0]  out_data_o
);

  localparam int unsigned SlotW = sca_pkg::SlotW;
  localparam int unsigned CntW  = sca_pkg::CntW;
  localparam int unsigned ListW = sca_pkg::ListW;
  localparam int unsigned IdxW  = sca_pkg::IdxW;

  // Configuration and pool control state.
  logic [CntW-1:0]                cpb_cfg_q;
  logic [sca_pkg::CfgSizeW-1:0]   size_cfg_q;
  logic [sca_pkg::NumSlots-1:0]   occupied_q;
  logic [sca_pkg::NumBuckets-1:0] nonempty_q;
  logic [CntW-1:0]                hint_q;
  logic [sca_pkg::BlkCntW-1:0]    count_q;
  logic                           out_valid_q;

  // Slot tables.
  logic [CntW-1:0]  fc_q [sca_pkg::NumSlots];
  logic [CntW-1:0]  ff_q [sca_pkg::NumSlots];
  logic [ListW-1:0] nx_q [sca_pkg::NumSlots];
  logic [ListW-1:0] pv_q [sca_pkg::NumSlots];

  // Request and working registers.
  logic                         req_free_q;
  logic [sca_pkg::SizeW-1:0]    req_size_q;
  logic [sca_pkg::HandleW-1:0]  req_handle_q;
  logic [SlotW-1:0]             s_q;
  logic [CntW-1:0]              idx_q;
  logic [CntW-1:0]              fcw_q;
  logic [ListW-1:0]             nxw_q;
  logic [ListW-1:0]             pvw_q;
  logic [IdxW-1:0]              fill_q;
  logic [CntW-1:0]              pb_q;
  sca_pkg::status_e             st_q;
  logic                         released_q;
  logic [sca_pkg::OutDataW-1:0] out_data_q;

  logic [CntW-1:0]              eff_cpb;
  logic [sca_pkg::CfgSizeW-1:0] eff_size;
  logic [SlotW-1:0]             req_slot;
  logic [IdxW-1:0]              req_idx;
  logic [SlotW-1:0]             empty_slot;
  logic                         have_empty;
  logic [ListW-1:0]             head_rd;
  logic [SlotW-1:0]             head_slot;
  logic [CntW-1:0]              link_rd;
  logic [SlotW-1:0]             rd_slot;
  logic [CntW:0]                fc_inc;
  logic [CntW-1:0]              fr_nf;
  logic [CntW-1:0]              al_nf;
  logic [CntW-1:0]              scan_hint;
  logic [CntW-1:0]              h1;
  logic [CntW-1:0]              hint_fix;
  logic [sca_pkg::HandleW-1:0]  granted;

  logic                         link_we;
  logic [8:0]                   link_waddr;
  logic [CntW-1:0]              link_wdata;
  logic [8:0]                   link_raddr;
  logic                         head_we;
  logic [CntW-1:0]              head_waddr;
  logic [ListW-1:0]             head_wdata;
  logic                         head_re;
  logic [CntW-1:0]              head_raddr;

  always_comb begin
    if (cpb_cfg_q == '0) begin
      eff_cpb = CntW'(1);
    end else if (cpb_cfg_q > sca_pkg::MaxCpb) begin
      eff_cpb = sca_pkg::MaxCpb;
    end else begin
      eff_cpb = cpb_cfg_q;
    end
    eff_size = (size_cfg_q < sca_pkg::MinChunkSize) ? sca_pkg::MinChunkSize : size_cfg_q;
  end

  assign req_slot  = req_handle_q[sca_pkg::HandleW-1:IdxW];
  assign req_idx   = req_handle_q[IdxW-1:0];
  assign head_slot = head_rd[SlotW-1:0];
  assign rd_slot   = (cmd_i == sca_pkg::CmdLoad) ? head_slot : req_slot;

  // Lowest empty slot.
  always_comb begin
    empty_slot = '0;
    have_empty = 1'b0;
    for (int i = sca_pkg::NumSlots - 1; i >= 0; i--) begin
      if (!occupied_q[i]) begin
        empty_slot = SlotW'(i);
        have_empty = 1'b1;
      end
    end
  end

  // Lowest nonempty bucket in 1..chunks_per_block.
  always_comb begin
    scan_hint = '0;
    for (int i = sca_pkg::NumBuckets - 1; i >= 1; i--) begin
      if (nonempty_q[i] && (CntW'(i) <= eff_cpb)) begin
        scan_hint = CntW'(i);
      end
    end
    h1       = (hint_q == '0) ? scan_hint : hint_q;
    hint_fix = (h1 == eff_cpb) ? '0 : h1;
  end

  assign fc_inc  = {1'b0, fcw_q} + (CntW+1)'(1);
  assign fr_nf   = (fc_inc > {1'b0, eff_cpb}) ? eff_cpb : fc_inc[CntW-1:0];
  assign al_nf   = fcw_q - CntW'(1);
  assign granted = (st_q == sca_pkg::StOk && !req_free_q) ? {s_q, idx_q[IdxW-1:0]} : '0;

  // Memory port selection.
  always_comb begin
    link_we    = (cmd_i == sca_pkg::CmdFill) || (cmd_i == sca_pkg::CmdFrLoad);
    if (cmd_i == sca_pkg::CmdFill) begin
      link_waddr = {s_q, fill_q};
      link_wdata = {1'b0, fill_q} + CntW'(1);
    end else begin
      link_waddr = {req_slot, req_idx};
      link_wdata = ff_q[req_slot];
    end
    link_raddr = {head_slot, ff_q[head_slot][IdxW-1:0]};

    head_we    = ((cmd_i == sca_pkg::CmdRemove) && (pvw_q == sca_pkg::NilSlot)) ||
                 (cmd_i == sca_pkg::CmdPushWr);
    if (cmd_i == sca_pkg::CmdRemove) begin
      head_waddr = fcw_q;
      head_wdata = nxw_q;
    end else begin
      head_waddr = pb_q;
      head_wdata = {1'b0, s_q};
    end
    head_re    = (cmd_i == sca_pkg::CmdPushRd) || (cmd_i == sca_pkg::CmdHeadRd);
    head_raddr = (cmd_i == sca_pkg::CmdPushRd) ? pb_q : hint_q;
  end

  sca_ram #(
    .Width (CntW),
    .Depth (sca_pkg::NumLinks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i == sca_pkg::CmdLoad),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  sca_ram #(
    .Width (ListW),
    .Depth (sca_pkg::NumBuckets)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rd)
  );

  // Control state; a configuration write empties the pool.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_cfg_q   <= sca_pkg::ChunksPerBlockRst;
      size_cfg_q  <= sca_pkg::ChunkSizeRst;
      occupied_q  <= '0;
      nonempty_q  <= '0;
      hint_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == sca_pkg::CmdFinish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (sca_pkg::cfg_reg_e'(cfg_index_i))
          sca_pkg::CfgChunksPerBlock: cpb_cfg_q  <= cfg_data_i[CntW-1:0];
          sca_pkg::CfgChunkSize:      size_cfg_q <= cfg_data_i;
          default: ;
        endcase
        occupied_q <= '0;
        nonempty_q <= '0;
        hint_q     <= '0;
        count_q    <= '0;
      end else begin
        unique case (cmd_i)
          sca_pkg::CmdOpen: begin
            occupied_q[empty_slot] <= 1'b1;
            count_q                <= count_q + sca_pkg::BlkCntW'(1);
            hint_q                 <= eff_cpb;
          end
          sca_pkg::CmdRemove: begin
            if (pvw_q == sca_pkg::NilSlot) begin
              nonempty_q[fcw_q] <= (nxw_q != sca_pkg::NilSlot);
            end
          end
          sca_pkg::CmdPushWr: nonempty_q[pb_q] <= 1'b1;
          sca_pkg::CmdAlUpd:  hint_q <= al_nf;
          sca_pkg::CmdAlHint: hint_q <= hint_fix;
          sca_pkg::CmdFrUpd: begin
            // The hint moves only when the old bucket just went empty.
            if (hint_q == fcw_q && !nonempty_q[fcw_q]) begin
              hint_q <= (fr_nf == eff_cpb) ? '0 : hint_q + CntW'(1);
            end
            if (fr_nf == eff_cpb) begin
              occupied_q[s_q] <= 1'b0;
              if (count_q != '0) begin
                count_q <= count_q - sca_pkg::BlkCntW'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Tables and working registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      sca_pkg::CmdAccept: begin
        req_free_q   <= in_user_i;
        req_size_q   <= in_data_i[15:0];
        req_handle_q <= in_data_i[24:16];
        st_q         <= sca_pkg::StOk;
        released_q   <= 1'b0;
      end
      sca_pkg::CmdErrSize: st_q <= sca_pkg::StSizeMismatch;
      sca_pkg::CmdErrSlot: st_q <= sca_pkg::StNoSlot;
      sca_pkg::CmdOpen: begin
        s_q              <= empty_slot;
        fc_q[empty_slot] <= eff_cpb;
        ff_q[empty_slot] <= '0;
        fill_q           <= '0;
        pb_q             <= eff_cpb;
      end
      sca_pkg::CmdFill:   fill_q <= fill_q + IdxW'(1);
      sca_pkg::CmdPushRd: pv_q[s_q] <= sca_pkg::NilSlot;
      sca_pkg::CmdPushWr: begin
        if (nonempty_q[pb_q]) begin
          nx_q[s_q]       <= head_rd;
          pv_q[head_slot] <= {1'b0, s_q};
        end else begin
          nx_q[s_q] <= sca_pkg::NilSlot;
        end
      end
      sca_pkg::CmdLoad: begin
        s_q   <= head_slot;
        idx_q <= ff_q[rd_slot];
        fcw_q <= fc_q[rd_slot];
        nxw_q <= nx_q[rd_slot];
        pvw_q <= pv_q[rd_slot];
      end
      sca_pkg::CmdRemove: begin
        if (pvw_q != sca_pkg::NilSlot) begin
          nx_q[pvw_q[SlotW-1:0]] <= nxw_q;
        end
        if (nxw_q != sca_pkg::NilSlot) begin
          pv_q[nxw_q[SlotW-1:0]] <= pvw_q;
        end
      end
      sca_pkg::CmdAlUpd: begin
        fc_q[s_q] <= al_nf;
        ff_q[s_q] <= link_rd;
        pb_q      <= al_nf;
      end
      sca_pkg::CmdFrLoad: begin
        s_q            <= req_slot;
        idx_q          <= {1'b0, req_idx};
        ff_q[req_slot] <= {1'b0, req_idx};
        fcw_q          <= fc_q[rd_slot];
        nxw_q          <= nx_q[rd_slot];
        pvw_q          <= pv_q[rd_slot];
      end
      sca_pkg::CmdFrUpd: begin
        fc_q[s_q] <= fr_nf;
        pb_q      <= fr_nf;
        if (fr_nf == eff_cpb) begin
          released_q <= 1'b1;
        end
      end
      sca_pkg::CmdFinish: begin
        out_data_q <= {7'd0, count_q, released_q, granted, st_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.is_free       = req_free_q;
    status_o.size_ok       = (req_size_q == {2'b00, eff_size});
    status_o.hint_zero     = (hint_q == '0);
    status_o.have_empty    = have_empty;
    status_o.hint_nonempty = nonempty_q[hint_q];
    status_o.slot_ok       = (idx_q < eff_cpb) && (fcw_q != '0);
    status_o.free_ok       = occupied_q[req_slot] && ({1'b0, req_idx} < eff_cpb);
    status_o.fill_last     = ({1'b0, fill_q} == (eff_cpb - CntW'(1)));
    status_o.release_blk   = (fr_nf == eff_cpb);
    status_o.out_busy      = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/sca_ctrl.sv =====
// ----------------------------------------------------------------------------
// Chunk allocator controller
// Sequences one request at a time through the datapath steps.
// ----------------------------------------------------------------------------
module sca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sca_pkg::dp_status_t status_i,
  output sca_pkg::cmd_e       cmd_o
);

  sca_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sca_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = sca_pkg::CmdNone;
    in_ready_o = 1'b0;
    unique case (state_q)
      sca_pkg::FsmIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = sca_pkg::CmdAccept;
          state_d = sca_pkg::FsmDispatch;
        end
      end
      sca_pkg::FsmDispatch: begin
        priority if (status_i.is_free) begin
          state_d = status_i.free_ok ? sca_pkg::FsmFrLoad : sca_pkg::FsmFinish;
        end else if (!status_i.size_ok) begin
          cmd_o   = sca_pkg::CmdErrSize;
          state_d = sca_pkg::FsmFinish;
        end else if (status_i.hint_zero) begin
          if (status_i.have_empty) begin
            state_d = sca_pkg::FsmOpen;
          end else begin
            cmd_o   = sca_pkg::CmdErrSlot;
            state_d = sca_pkg::FsmFinish;
          end
        end else if (status_i.hint_nonempty) begin
          cmd_o   = sca_pkg::CmdHeadRd;
          state_d = sca_pkg::FsmAlLoad;
        end else begin
          cmd_o   = sca_pkg::CmdErrSlot;
          state_d = sca_pkg::FsmFinish;
        end
      end
      sca_pkg::FsmOpen: begin
        cmd_o   = sca_pkg::CmdOpen;
        state_d = sca_pkg::FsmFill;
      end
      sca_pkg::FsmFill: begin
        cmd_o = sca_pkg::CmdFill;
        if (status_i.fill_last) begin
          state_d = sca_pkg::FsmOpenPushRd;
        end
      end
      sca_pkg::FsmOpenPushRd: begin
        cmd_o   = sca_pkg::CmdPushRd;
        state_d = sca_pkg::FsmOpenPushWr;
      end
      sca_pkg::FsmOpenPushWr: begin
        cmd_o   = sca_pkg::CmdPushWr;
        state_d = sca_pkg::FsmAlHead;
      end
      sca_pkg::FsmAlHead: begin
        cmd_o   = sca_pkg::CmdHeadRd;
        state_d = sca_pkg::FsmAlLoad;
      end
      sca_pkg::FsmAlLoad: begin
        cmd_o   = sca_pkg::CmdLoad;
        state_d = sca_pkg::FsmAlCheck;
      end
      sca_pkg::FsmAlCheck: begin
        if (status_i.slot_ok) begin
          state_d = sca_pkg::FsmAlRemove;
        end else begin
          cmd_o   = sca_pkg::CmdErrSlot;
          state_d = sca_pkg::FsmFinish;
        end
      end
      sca_pkg::FsmAlRemove: begin
        cmd_o   = sca_pkg::CmdRemove;
        state_d = sca_pkg::FsmAlUpd;
      end
      sca_pkg::FsmAlUpd: begin
        cmd_o   = sca_pkg::CmdAlUpd;
        state_d = sca_pkg::FsmAlPushRd;
      end
      sca_pkg::FsmAlPushRd: begin
        cmd_o   = sca_pkg::CmdPushRd;
        state_d = sca_pkg::FsmAlPushWr;
      end
      sca_pkg::FsmAlPushWr: begin
        cmd_o   = sca_pkg::CmdPushWr;
        state_d = sca_pkg::FsmAlHint;
      end
      sca_pkg::FsmAlHint: begin
        cmd_o   = sca_pkg::CmdAlHint;
        state_d = sca_pkg::FsmFinish;
      end
      sca_pkg::FsmFrLoad: begin
        cmd_o   = sca_pkg::CmdFrLoad;
        state_d = sca_pkg::FsmFrRemove;
      end
      sca_pkg::FsmFrRemove: begin
        cmd_o   = sca_pkg::CmdRemove;
        state_d = sca_pkg::FsmFrUpd;
      end
      sca_pkg::FsmFrUpd: begin
        cmd_o   = sca_pkg::CmdFrUpd;
        state_d = status_i.release_blk ? sca_pkg::FsmFinish : sca_pkg::FsmFrPushRd;
      end
      sca_pkg::FsmFrPushRd: begin
        cmd_o   = sca_pkg::CmdPushRd;
        state_d = sca_pkg::FsmFrPushWr;
      end
      sca_pkg::FsmFrPushWr: begin
        cmd_o   = sca_pkg::CmdPushWr;
        state_d = sca_pkg::FsmFinish;
      end
      sca_pkg::FsmFinish: begin
        // Wait here while the output register still holds an untaken result.
        if (!status_i.out_busy) begin
          cmd_o   = sca_pkg::CmdFinish;
          state_d = sca_pkg::FsmIdle;
        end
      end
      default: state_d = sca_pkg::FsmIdle;
    endcase
  end

endmodule

// ===== sv/sca_checker.sv =====
// ----------------------------------------------------------------------------
// Chunk allocator port checker
// Checks result consistency and output stability seen at the ports.
// ----------------------------------------------------------------------------
module sca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [sca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [sca_pkg::CfgDataW-1:0]  cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sca_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sca_pkg::OutDataW-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != sca_pkg::StOk |-> m_axis_tdata[11:2] == '0)
    else $error("error result carries a handle or a release");

  a_blocks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:12] == '0)
    else $error("more than sixteen blocks in use");

endmodule

bind slab_chunk_allocator sca_checker u_sca_checker (.*);
